// ===== rtl/sbms_pkg.sv =====
// Package for the sparse bit matrix store: sizes, entry layout, controller states
// and the command and status structs that join controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sbms_pkg;

  localparam int NUM_INDICES     = 256;
  localparam int MAX_ENTRIES     = 32;
  localparam int INDEX_BITS      = 8;
  localparam int SLOT_BITS       = $clog2(MAX_ENTRIES);
  localparam int CNT_BITS        = $clog2(MAX_ENTRIES + 1);
  localparam int OFFSET_BITS     = 5;
  localparam int MASK_BITS       = 8;
  localparam int BIT_SEL_BITS    = 3;
  localparam int ENTRY_BITS      = OFFSET_BITS + MASK_BITS;
  localparam int ENTRY_DEPTH     = NUM_INDICES * MAX_ENTRIES;

  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] offset;
    logic [MASK_BITS-1:0]   mask;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COUNT_RD,
    ST_COUNT_CAP,
    ST_SEARCH,
    ST_PROBE,
    ST_SHIFT,
    ST_SHIFT_WR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_item;
    logic cnt_capture;
    logic probe_rd;
    logic probe_eval;
    logic set_full;
    logic start_shift;
    logic shift_rd;
    logic shift_wr;
    logic insert;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic diag;
    logic is_check;
    logic search_open;
    logic cmp_less;
    logic cmp_greater;
    logic col_full;
    logic shift_more;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/sbms_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module sbms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/sbms_ctrl.sv =====
// Controller state machine of the sparse bit matrix store.
// Depends on sbms_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module sbms_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sbms_pkg::dp_status_t sts,
  output sbms_pkg::ctrl_cmd_t      cmd
);

  sbms_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbms_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sbms_pkg::ST_IDLE: begin
        if (in_valid) state_next = sbms_pkg::ST_COUNT_RD;
      end
      sbms_pkg::ST_COUNT_RD:  state_next = sbms_pkg::ST_COUNT_CAP;
      sbms_pkg::ST_COUNT_CAP: begin
        state_next = sts.diag ? sbms_pkg::ST_FINISH : sbms_pkg::ST_SEARCH;
      end
      sbms_pkg::ST_SEARCH: begin
        if (sts.search_open) begin
          state_next = sbms_pkg::ST_PROBE;
        end else if (sts.is_check || sts.col_full) begin
          state_next = sbms_pkg::ST_FINISH;
        end else begin
          state_next = sbms_pkg::ST_SHIFT;
        end
      end
      sbms_pkg::ST_PROBE: begin
        if (sts.cmp_less || sts.cmp_greater) begin
          state_next = sbms_pkg::ST_SEARCH;
        end else begin
          state_next = sbms_pkg::ST_FINISH;
        end
      end
      sbms_pkg::ST_SHIFT: begin
        state_next = sts.shift_more ? sbms_pkg::ST_SHIFT_WR : sbms_pkg::ST_FINISH;
      end
      sbms_pkg::ST_SHIFT_WR: state_next = sbms_pkg::ST_SHIFT;
      sbms_pkg::ST_FINISH: begin
        if (sts.out_free) state_next = sbms_pkg::ST_IDLE;
      end
      default: state_next = sbms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      sbms_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      sbms_pkg::ST_COUNT_CAP: cmd.cnt_capture = 1'b1;
      sbms_pkg::ST_SEARCH: begin
        if (sts.search_open) begin
          cmd.probe_rd = 1'b1;
        end else if (!sts.is_check) begin
          if (sts.col_full) begin
            cmd.set_full = 1'b1;
          end else begin
            cmd.start_shift = 1'b1;
          end
        end
      end
      sbms_pkg::ST_PROBE: cmd.probe_eval = 1'b1;
      sbms_pkg::ST_SHIFT: begin
        if (sts.shift_more) begin
          cmd.shift_rd = 1'b1;
        end else begin
          cmd.insert = 1'b1;
        end
      end
      sbms_pkg::ST_SHIFT_WR: cmd.shift_wr = 1'b1;
      sbms_pkg::ST_FINISH:   cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/sbms_dp.sv =====
// Datapath of the sparse bit matrix store: item registers, search bounds,
// column count and entry RAMs, column valid bits and the output register.
// Depends on sbms_pkg and sbms_ram.
`timescale 1ns / 1ps
`default_nettype none

module sbms_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 command,
  input  wire logic [sbms_pkg::INDEX_BITS-1:0]      first_index,
  input  wire logic [sbms_pkg::INDEX_BITS-1:0]      second_index,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      bit_value,
  output logic                                      status,
  input  wire sbms_pkg::ctrl_cmd_t                  cmd,
  output sbms_pkg::dp_status_t                      sts
);

  localparam int AddrBits = sbms_pkg::INDEX_BITS + sbms_pkg::SLOT_BITS;

  logic                                 is_check;
  logic                                 diag;
  logic [sbms_pkg::INDEX_BITS-1:0]      col;
  logic [sbms_pkg::OFFSET_BITS-1:0]     byte_off;
  logic [sbms_pkg::MASK_BITS-1:0]       bit_sel;
  logic [sbms_pkg::CNT_BITS-1:0]        lo;
  logic [sbms_pkg::CNT_BITS-1:0]        hi;
  logic [sbms_pkg::CNT_BITS-1:0]        n;
  logic [sbms_pkg::CNT_BITS-1:0]        idx;
  logic [sbms_pkg::SLOT_BITS-1:0]       mid;
  logic                                 res_bit;
  logic                                 res_status;
  logic [sbms_pkg::NUM_INDICES-1:0]     col_valid;

  logic [sbms_pkg::INDEX_BITS-1:0]      lo_index;
  logic [sbms_pkg::INDEX_BITS-1:0]      hi_index;
  logic [sbms_pkg::CNT_BITS:0]          bound_sum;
  logic [sbms_pkg::SLOT_BITS-1:0]       mid_calc;
  logic [sbms_pkg::CNT_BITS-1:0]        idx_prev;
  logic [sbms_pkg::CNT_BITS-1:0]        cnt_rdata;
  logic [sbms_pkg::CNT_BITS-1:0]        cnt_val;
  logic                                 cnt_we;
  logic [sbms_pkg::ENTRY_BITS-1:0]      ent_rdata;
  sbms_pkg::entry_t                     ent;
  sbms_pkg::entry_t                     ent_wdata;
  logic                                 ent_we;
  logic [AddrBits-1:0]                  ent_waddr;
  logic [AddrBits-1:0]                  ent_raddr;
  logic                                 found_set;

  assign lo_index  = (first_index < second_index) ? first_index : second_index;
  assign hi_index  = (first_index < second_index) ? second_index : first_index;
  assign bound_sum = {1'b0, lo} + {1'b0, hi};
  assign mid_calc  = bound_sum[sbms_pkg::SLOT_BITS:1];
  assign idx_prev  = idx - sbms_pkg::CNT_BITS'(1);
  assign cnt_val   = col_valid[col] ? cnt_rdata : '0;
  assign ent       = sbms_pkg::entry_t'(ent_rdata);

  assign sts.diag        = diag;
  assign sts.is_check    = is_check;
  assign sts.search_open = lo < hi;
  assign sts.cmp_less    = ent.offset < byte_off;
  assign sts.cmp_greater = ent.offset > byte_off;
  assign sts.col_full    = n >= sbms_pkg::CNT_BITS'(sbms_pkg::MAX_ENTRIES);
  assign sts.shift_more  = idx > lo;
  assign sts.out_free    = !out_valid || out_ready;

  assign found_set = cmd.probe_eval && (ent.offset == byte_off) && !is_check;

  // Entry RAM address and data selection.
  always_comb begin
    ent_raddr = {col, mid_calc};
    if (cmd.shift_rd) ent_raddr = {col, idx_prev[sbms_pkg::SLOT_BITS-1:0]};

    ent_we    = 1'b0;
    ent_waddr = {col, mid};
    ent_wdata = '{offset: ent.offset, mask: ent.mask | bit_sel};
    if (found_set) begin
      ent_we = 1'b1;
    end else if (cmd.shift_wr) begin
      ent_we    = 1'b1;
      ent_waddr = {col, idx[sbms_pkg::SLOT_BITS-1:0]};
      ent_wdata = ent;
    end else if (cmd.insert) begin
      ent_we    = 1'b1;
      ent_waddr = {col, lo[sbms_pkg::SLOT_BITS-1:0]};
      ent_wdata = '{offset: byte_off, mask: bit_sel};
    end
  end

  assign cnt_we = cmd.insert;

  sbms_ram #(
    .WIDTH(sbms_pkg::CNT_BITS),
    .DEPTH(sbms_pkg::NUM_INDICES)
  ) u_count_ram (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(col),
    .wdata(n + sbms_pkg::CNT_BITS'(1)),
    .raddr(col),
    .rdata(cnt_rdata)
  );

  sbms_ram #(
    .WIDTH(sbms_pkg::ENTRY_BITS),
    .DEPTH(sbms_pkg::ENTRY_DEPTH)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ent_we),
    .waddr(ent_waddr),
    .wdata(ent_wdata),
    .raddr(ent_raddr),
    .rdata(ent_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      is_check   <= command;
      diag       <= first_index == second_index;
      col        <= lo_index;
      byte_off   <= hi_index[sbms_pkg::INDEX_BITS-1:sbms_pkg::BIT_SEL_BITS];
      bit_sel    <= sbms_pkg::MASK_BITS'(1) << hi_index[sbms_pkg::BIT_SEL_BITS-1:0];
      res_bit    <= (first_index == second_index) && (command == sbms_pkg::CMD_CHECK);
      res_status <= sbms_pkg::STATUS_OK;
    end
    if (cmd.cnt_capture) begin
      n  <= cnt_val;
      hi <= cnt_val;
      lo <= '0;
    end
    if (cmd.probe_rd) mid <= mid_calc;
    if (cmd.probe_eval) begin
      if (sts.cmp_less) begin
        lo <= sbms_pkg::CNT_BITS'(mid) + sbms_pkg::CNT_BITS'(1);
      end else if (sts.cmp_greater) begin
        hi <= sbms_pkg::CNT_BITS'(mid);
      end else if (is_check) begin
        res_bit <= |(ent.mask & bit_sel);
      end
    end
    if (cmd.set_full)    res_status <= sbms_pkg::STATUS_FULL;
    if (cmd.start_shift) idx <= n;
    if (cmd.shift_wr)    idx <= idx_prev;
    if (cmd.out_load) begin
      bit_value <= res_bit;
      status    <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      col_valid <= '0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.insert) col_valid[col] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sparse_bit_matrix_store.sv =====
// Top level of the sparse bit matrix store: joins the controller and the datapath.
// Depends on sbms_pkg, sbms_ctrl, sbms_dp (and through it sbms_ram).
`timescale 1ns / 1ps
`default_nettype none

// The store keeps one bit for every unordered pair of 8-bit indices. The smaller
// index of a pair picks a column and the larger one is the row; each column holds
// up to 32 entries, sorted by byte offset (row / 8), each with an 8-bit mask. A set
// transaction ORs the bit into the entry found by binary search, or shifts the
// tail of the column up one slot and inserts a new entry; if the column is full,
// the set is dropped and status reports 1. A check transaction returns the stored
// bit, 1 on the diagonal. Every input transaction yields exactly one output
// transaction. Items are handled one at a time: an item reads and captures its
// column count, then runs the binary search (at most 6 probes), then on an insert
// shifts the entries at and after the insert slot up one by one and writes the
// new entry, and last loads the output register. Every probe and every shifted
// entry goes through the single read port of the entry RAM with a registered
// read. A result still waiting in the output register holds the item in its
// finish state until the register frees. Column counts sit in a RAM with one
// valid flip-flop per column that reset clears, so the block is ready in the
// cycle after reset with no clearing pass. A finished result waits in the output
// register while the next item is taken.

module sparse_bit_matrix_store (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            command,
  input  wire logic [sbms_pkg::INDEX_BITS-1:0] first_index,
  input  wire logic [sbms_pkg::INDEX_BITS-1:0] second_index,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 bit_value,
  output logic                                 status
);

  // Commands from the controller, status flags from the datapath.
  sbms_pkg::ctrl_cmd_t  cmd;
  sbms_pkg::dp_status_t sts;

  sbms_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  sbms_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .command     (command),
    .first_index (first_index),
    .second_index(second_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bit_value   (bit_value),
    .status      (status),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

`default_nettype wire
